[rtl/assert_macros.svh]
// Assertion helpers for the escape-time RTL.
// Each macro takes a label, a clock, a reset and a property expression.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_PROP(label, clk, rst, !(expr))

`else

`define ASSERT_PROP(label, clk, rst, prop)

`define ASSERT_NEVER(label, clk, rst, expr)

`endif

`endif

[rtl/bship_pkg.sv]
`default_nettype none

package bship_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int PIX_W   = 10;
   localparam int ITER_W  = 11;
   localparam int PAL_W   = 9;
   localparam int COLOR_W = 8;
   localparam int Z_W     = 31;
   localparam int PROD_W  = 2 * Z_W;
   localparam int WIDE_W  = 64;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MAX_ITER = 1'b0;
   localparam logic CSR_IDX_PALETTE  = 1'b1;

   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 11'd64;
   localparam logic [PAL_W-1:0]  PALETTE_RESET  = 9'd16;

   // saturation bounds of the signed 32-bit range
   localparam logic signed [WIDE_W-1:0] SAT_POS = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [WIDE_W-1:0] SAT_NEG = 64'shFFFF_FFFF_8000_0000;

   // sequencer: one multiply per step, three per iteration, then update
   typedef enum logic [2:0] {
      S_IDLE,
      S_RR,
      S_II,
      S_RI,
      S_UPD,
      S_DONE
   } state_type;

   // clamp to signed 32 bits, then absolute value clamped to 2^31-1
   function automatic logic [Z_W-1:0] sat_abs(input logic signed [WIDE_W-1:0] v);
      logic signed [COORD_W-1:0] s;
      logic signed [COORD_W-1:0] neg;
      if (v > SAT_POS) begin
         s = SAT_POS[COORD_W-1:0];
      end else if (v < SAT_NEG) begin
         s = SAT_NEG[COORD_W-1:0];
      end else begin
         s = v[COORD_W-1:0];
      end
      neg = -s;
      if (s == SAT_NEG[COORD_W-1:0]) begin
         return SAT_POS[Z_W-1:0];
      end else if (s < 0) begin
         return neg[Z_W-1:0];
      end else begin
         return s[Z_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

[rtl/burning_ship_escape_time_top.sv]
// Burning Ship escape-time unit.
// Request channel (req_valid/req_ready) takes one point c in signed fixed
// point plus a pixel tag. Response channel (rsp_valid/rsp_ready) returns the
// tag, the escape flag, the iteration count and the palette index.
// One point is worked at a time; req_ready is high only while the sequencer
// is idle. Each iteration steps through S_RR, S_II, S_RI and S_UPD on a single
// shared 31x31 multiplier (zr*zr, zi*zi, zr*zi, then the escape test result
// and the z update). rsp_valid rises once a point escapes or runs to the
// limit; a zero limit sends the point from idle straight to the result. The
// next point is taken only once that result is loaded and the sequencer is
// back in idle, so the iteration limit sets the throughput.
// A result waits in an output register; when the receiver stalls, the
// finished point holds the sequencer until the register frees up, and a new
// point is taken in the cycle after that result is loaded.
// Registers on the APB port: 0x0 max_iterations (11 bits, reset 64),
// 0x4 palette_size (9 bits, reset 16). Write them only while idle.
// Synchronous active-high reset returns the sequencer to idle, drops
// rsp_valid and restores the register defaults.
`default_nettype none
`include "assert_macros.svh"

module burning_ship_escape_time_top #(
   parameter int ITER_LIMIT_MAX = 1024,
   parameter int PALETTE_MAX    = 256,
   parameter int FRAC_BITS      = 28
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [bship_pkg::COORD_W-1:0] req_c_real,
   input  wire logic signed [bship_pkg::COORD_W-1:0] req_c_imag,
   input  wire logic [bship_pkg::PIX_W-1:0]          req_pixel_x,
   input  wire logic [bship_pkg::PIX_W-1:0]          req_pixel_y,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [bship_pkg::PIX_W-1:0]               rsp_out_x,
   output logic [bship_pkg::PIX_W-1:0]               rsp_out_y,
   output logic                                      rsp_escaped,
   output logic [bship_pkg::ITER_W-1:0]              rsp_iteration_count,
   output logic [bship_pkg::COLOR_W-1:0]             rsp_color_index,
   // configuration port
   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [bship_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [bship_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [bship_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                      csr_pready
);

   localparam int ITER_W  = bship_pkg::ITER_W;
   localparam int PAL_W   = bship_pkg::PAL_W;
   localparam int Z_W     = bship_pkg::Z_W;
   localparam int PROD_W  = bship_pkg::PROD_W;
   localparam int WIDE_W  = bship_pkg::WIDE_W;
   localparam int COORD_W = bship_pkg::COORD_W;
   localparam int PIX_W   = bship_pkg::PIX_W;
   localparam int COLOR_W = bship_pkg::COLOR_W;

   localparam logic [WIDE_W-1:0] ESC_BOUND = 64'd4 << FRAC_BITS;

   // configuration registers
   logic [ITER_W-1:0] max_iter_ff, max_iter_in;
   logic [PAL_W-1:0]  palette_ff, palette_in;

   // sequencer and datapath registers
   bship_pkg::state_type state_ff, state_in;
   logic signed [COORD_W-1:0] c_real_ff, c_real_in;
   logic signed [COORD_W-1:0] c_imag_ff, c_imag_in;
   logic [PIX_W-1:0]          pix_x_ff, pix_x_in;
   logic [PIX_W-1:0]          pix_y_ff, pix_y_in;
   logic [Z_W-1:0]            zr_ff, zr_in;
   logic [Z_W-1:0]            zi_ff, zi_in;
   logic [PROD_W-1:0]         rr_ff, rr_in;
   logic [PROD_W-1:0]         ii_ff, ii_in;
   logic [PROD_W-1:0]         ri_ff, ri_in;
   logic signed [WIDE_W-1:0]  diff_ff, diff_in;
   logic                      esc_ff, esc_in;
   logic [ITER_W-1:0]         iter_ff, iter_in;
   logic [PAL_W-1:0]          color_ff, color_in;

   // output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]          rsp_x_ff, rsp_x_in;
   logic [PIX_W-1:0]          rsp_y_ff, rsp_y_in;
   logic                      rsp_esc_ff, rsp_esc_in;
   logic [ITER_W-1:0]         rsp_cnt_ff, rsp_cnt_in;
   logic [COLOR_W-1:0]        rsp_color_ff, rsp_color_in;

   // shared multiplier
   logic [Z_W-1:0]    mul_a, mul_b;
   logic [PROD_W-1:0] mul_p;

   logic [ITER_W-1:0]        limit_eff;
   logic [PAL_W-1:0]         pal_eff;
   logic [WIDE_W-1:0]        mag;
   logic signed [WIDE_W-1:0] nr, ni;
   logic [WIDE_W-1:0]        ri_shift;
   logic [ITER_W-1:0]        iter_next;
   logic [PAL_W-1:0]         color_next;
   logic                     csr_wr;
   logic                     esc_out;

   // clamp the register values to the supported maxima
   assign limit_eff = (32'(max_iter_ff) > 32'(ITER_LIMIT_MAX)) ?
                      ITER_W'(ITER_LIMIT_MAX) : max_iter_ff;
   assign pal_eff   = (32'(palette_ff) > 32'(PALETTE_MAX)) ?
                      PAL_W'(PALETTE_MAX) : palette_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == bship_pkg::CSR_IDX_PALETTE) ?
                       {{(32 - PAL_W){1'b0}}, palette_ff} :
                       {{(32 - ITER_W){1'b0}}, max_iter_ff};

   always_comb begin
      max_iter_in = max_iter_ff;
      palette_in  = palette_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            bship_pkg::CSR_IDX_MAX_ITER: max_iter_in = csr_pwdata[ITER_W-1:0];
            bship_pkg::CSR_IDX_PALETTE:  palette_in  = csr_pwdata[PAL_W-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier
   always_comb begin
      unique case (state_ff)
         bship_pkg::S_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         bship_pkg::S_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
      endcase
   end
   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // escape test and z update terms (diff is signed so its shift floors)
   assign mag        = WIDE_W'(rr_ff) + WIDE_W'(ii_ff);
   assign ri_shift   = WIDE_W'({1'b0, ri_ff, 1'b0}) >> FRAC_BITS;
   assign nr         = (diff_ff >>> FRAC_BITS) +
                       $signed({{(WIDE_W - COORD_W){c_real_ff[COORD_W-1]}}, c_real_ff});
   assign ni         = $signed(ri_shift) +
                       $signed({{(WIDE_W - COORD_W){c_imag_ff[COORD_W-1]}}, c_imag_ff});
   assign iter_next  = iter_ff + 1'b1;
   assign color_next = (color_ff + 1'b1 == pal_eff) ? '0 : color_ff + 1'b1;
   assign esc_out    = (iter_ff != limit_eff);

   assign req_ready = (state_ff == bship_pkg::S_IDLE);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      c_real_in    = c_real_ff;
      c_imag_in    = c_imag_ff;
      pix_x_in     = pix_x_ff;
      pix_y_in     = pix_y_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      rr_in        = rr_ff;
      ii_in        = ii_ff;
      ri_in        = ri_ff;
      diff_in      = diff_ff;
      esc_in       = esc_ff;
      iter_in      = iter_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_esc_in   = rsp_esc_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_color_in = rsp_color_ff;
      unique case (state_ff)
         bship_pkg::S_IDLE: begin
            if (req_valid) begin
               c_real_in = req_c_real;
               c_imag_in = req_c_imag;
               pix_x_in  = req_pixel_x;
               pix_y_in  = req_pixel_y;
               zr_in     = '0;
               zi_in     = '0;
               iter_in   = '0;
               color_in  = '0;
               state_in  = (limit_eff == '0) ? bship_pkg::S_DONE : bship_pkg::S_RR;
            end
         end
         bship_pkg::S_RR: begin
            rr_in    = mul_p;
            state_in = bship_pkg::S_II;
         end
         bship_pkg::S_II: begin
            ii_in    = mul_p;
            state_in = bship_pkg::S_RI;
         end
         bship_pkg::S_RI: begin
            // cross product, escape test and real-part difference in parallel
            ri_in    = mul_p;
            esc_in   = (mag >> FRAC_BITS) >= ESC_BOUND;
            diff_in  = $signed(WIDE_W'(rr_ff)) - $signed(WIDE_W'(ii_ff));
            state_in = bship_pkg::S_UPD;
         end
         bship_pkg::S_UPD: begin
            if (esc_ff) begin
               state_in = bship_pkg::S_DONE;
            end else begin
               zr_in    = bship_pkg::sat_abs(nr);
               zi_in    = bship_pkg::sat_abs(ni);
               iter_in  = iter_next;
               color_in = color_next;
               state_in = (iter_next == limit_eff) ? bship_pkg::S_DONE : bship_pkg::S_RR;
            end
         end
         bship_pkg::S_DONE: begin
            // load the output register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = pix_x_ff;
               rsp_y_in     = pix_y_ff;
               rsp_esc_in   = esc_out;
               rsp_cnt_in   = iter_ff;
               rsp_color_in = (esc_out && pal_eff != '0) ? color_ff[COLOR_W-1:0] : '0;
               state_in     = bship_pkg::S_IDLE;
            end
         end
         default: state_in = bship_pkg::S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bship_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= bship_pkg::MAX_ITER_RESET;
         palette_ff   <= bship_pkg::PALETTE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         max_iter_ff  <= max_iter_in;
         palette_ff   <= palette_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      c_real_ff    <= c_real_in;
      c_imag_ff    <= c_imag_in;
      pix_x_ff     <= pix_x_in;
      pix_y_ff     <= pix_y_in;
      zr_ff        <= zr_in;
      zi_ff        <= zi_in;
      rr_ff        <= rr_in;
      ii_ff        <= ii_in;
      ri_ff        <= ri_in;
      diff_ff      <= diff_in;
      esc_ff       <= esc_in;
      iter_ff      <= iter_in;
      color_ff     <= color_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_esc_ff   <= rsp_esc_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_out_x           = rsp_x_ff;
   assign rsp_out_y           = rsp_y_ff;
   assign rsp_escaped         = rsp_esc_ff;
   assign rsp_iteration_count = rsp_cnt_ff;
   assign rsp_color_index     = rsp_color_ff;

   // checks
   `ASSERT_PROP(a_accept_starts, clock, reset,
      (req_valid && req_ready) |=> (state_ff != bship_pkg::S_IDLE))
   `ASSERT_NEVER(a_iter_bound, clock, reset,
      (state_ff != bship_pkg::S_IDLE) && (iter_ff > limit_eff))
   `ASSERT_NEVER(a_color_bound, clock, reset,
      (state_ff != bship_pkg::S_IDLE) && (pal_eff != '0) && (color_ff >= pal_eff))
   `ASSERT_PROP(a_done_loads, clock, reset,
      ((state_ff == bship_pkg::S_DONE) && !rsp_valid_ff) |=> rsp_valid_ff)

endmodule

`default_nettype wire

[tb/tb_burning_ship_escape_time_top.sv]
`timescale 1ns / 1ps

module tb_burning_ship_escape_time_top;

   localparam int COORD_W    = bship_pkg::COORD_W;
   localparam int PIX_W      = bship_pkg::PIX_W;
   localparam int ITER_W     = bship_pkg::ITER_W;
   localparam int PAL_W      = bship_pkg::PAL_W;
   localparam int COLOR_W    = bship_pkg::COLOR_W;
   localparam int CSR_ADDR_W = bship_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = bship_pkg::CSR_DATA_W;

   localparam int ITER_CAP      = 1024;
   localparam int PALETTE_CAP   = 256;
   localparam int FRAC          = 28;
   localparam int SETTLE_CYCLES = 20;
   localparam int STALL_LIMIT   = 20000;
   localparam int HOLD_AFTER    = 90;
   localparam int HOLD_CYCLES   = 500;

   localparam longint Z_MAX      = 64'sd2147483647;
   localparam longint Z_MIN      = -64'sd2147483648;
   localparam longint ESCAPE_MAG = longint'(1) << (2 * FRAC + 2);

   localparam logic [COORD_W-1:0] Q_HALF = 32'h0800_0000;
   localparam logic [COORD_W-1:0] Q_ONE  = 32'h1000_0000;
   localparam logic [COORD_W-1:0] Q_TWO  = 32'h2000_0000;

   // expected result of one point
   typedef struct {
      logic [PIX_W-1:0]   x;
      logic [PIX_W-1:0]   y;
      logic               esc;
      logic [ITER_W-1:0]  count;
      logic [COLOR_W-1:0] color;
   } pixel_verdict_type;

   // escape-time predictor plus the queue of results still owed by the block
   class escape_scoreboard_type;
      pixel_verdict_type verdicts[$];
      logic [ITER_W-1:0] iter_limit_reg;
      logic [PAL_W-1:0]  palette_reg;
      int                mismatches;
      int                checked;

      function new();
         iter_limit_reg = bship_pkg::MAX_ITER_RESET;
         palette_reg    = bship_pkg::PALETTE_RESET;
         mismatches     = 0;
         checked        = 0;
      endfunction

      function void write_reg(logic idx, logic [CSR_DATA_W-1:0] value);
         if (idx == bship_pkg::CSR_IDX_MAX_ITER) begin
            iter_limit_reg = value[ITER_W-1:0];
         end else begin
            palette_reg = value[PAL_W-1:0];
         end
      endfunction

      // clamp to signed 32 bits, then magnitude clamped to 2^31-1
      function longint fold_abs(longint v);
         if (v > Z_MAX) v = Z_MAX;
         if (v < Z_MIN) v = Z_MIN;
         if (v < 0) v = -v;
         if (v > Z_MAX) v = Z_MAX;
         return v;
      endfunction

      function void note_point(logic signed [COORD_W-1:0] cr, logic signed [COORD_W-1:0] ci,
                               logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
         longint            zr, zi, rr, ii, nr;
         int                limit, pal, n;
         pixel_verdict_type v;
         limit = (iter_limit_reg > ITER_CAP) ? ITER_CAP : int'(iter_limit_reg);
         pal   = (palette_reg > PALETTE_CAP) ? PALETTE_CAP : int'(palette_reg);
         zr = 0;
         zi = 0;
         n  = 0;
         // escape test on the exact |z|^2, update with floor shift
         while (n < limit) begin
            rr = zr * zr;
            ii = zi * zi;
            if (rr + ii >= ESCAPE_MAG) break;
            nr = ((rr - ii) >>> FRAC) + longint'(cr);
            zi = fold_abs(((2 * zr * zi) >>> FRAC) + longint'(ci));
            zr = fold_abs(nr);
            n++;
         end
         v.x     = px;
         v.y     = py;
         v.esc   = (n != limit);
         v.count = ITER_W'(n);
         v.color = (v.esc && pal != 0) ? COLOR_W'(n % pal) : '0;
         verdicts.push_back(v);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic esc,
                                 logic [ITER_W-1:0] count, logic [COLOR_W-1:0] color);
         pixel_verdict_type v;
         if (verdicts.size() == 0) begin
            $error("result for pixel (%0d,%0d) with no point outstanding", x, y);
            mismatches++;
            return;
         end
         v = verdicts.pop_front();
         checked++;
         compare_field("out_x", v.x, x);
         compare_field("out_y", v.y, y);
         compare_field("escaped", v.esc, esc);
         compare_field("iteration_count", v.count, count);
         compare_field("color_index", v.color, color);
      endfunction
   endclass

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    req_valid   = 1'b0;
   logic                    req_ready;
   logic [COORD_W-1:0]      req_c_real  = '0;
   logic [COORD_W-1:0]      req_c_imag  = '0;
   logic [PIX_W-1:0]        req_pixel_x = '0;
   logic [PIX_W-1:0]        req_pixel_y = '0;
   logic                    rsp_valid;
   logic                    rsp_ready   = 1'b0;
   logic [PIX_W-1:0]        rsp_out_x;
   logic [PIX_W-1:0]        rsp_out_y;
   logic                    rsp_escaped;
   logic [ITER_W-1:0]       rsp_iteration_count;
   logic [COLOR_W-1:0]      rsp_color_index;
   logic                    csr_psel    = 1'b0;
   logic                    csr_penable = 1'b0;
   logic                    csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_paddr   = '0;
   logic [CSR_DATA_W-1:0]   csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0]   csr_prdata;
   logic                    csr_pready;

   escape_scoreboard_type sb;
   bit                    idle_on = 1'b1;

   burning_ship_escape_time_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_c_real          (req_c_real),
      .req_c_imag          (req_c_imag),
      .req_pixel_x         (req_pixel_x),
      .req_pixel_y         (req_pixel_y),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_x           (rsp_out_x),
      .rsp_out_y           (rsp_out_y),
      .rsp_escaped         (rsp_escaped),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_color_index     (rsp_color_index),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // idle length: mostly none or short, now and then long
   function automatic int gap_cycles();
      int roll;
      if (!idle_on) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [COORD_W-1:0] spread(input logic [COORD_W-1:0] center,
                                                 input logic [COORD_W-1:0] span);
      return center + $urandom_range(0, 2 * span) - span;
   endfunction

   function automatic logic [COORD_W-1:0] corner_coord();
      case ($urandom_range(0, 6))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         4: return Q_TWO;
         5: return -Q_TWO;
         default: return Q_TWO - 1;
      endcase
   endfunction

   // offer one point; returns at the edge where it is taken
   task automatic send_point(input logic [COORD_W-1:0] cr, input logic [COORD_W-1:0] ci,
                             input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
      int gap;
      gap = gap_cycles();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_c_real  <= cr;
      req_c_imag  <= ci;
      req_pixel_x <= px;
      req_pixel_y <= py;
      do @(posedge clock); while (!req_ready);
   endtask

   // one APB transfer: setup cycle, then access until pready
   task automatic csr_access(input logic wr, input logic idx, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // write a register with random unused upper bits, then read it back
   task automatic program_reg(input logic idx, input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] mask, data, readback;
      mask = (idx == bship_pkg::CSR_IDX_MAX_ITER) ? (32'd1 << ITER_W) - 1 :
                                                    (32'd1 << PAL_W) - 1;
      data = (value & mask) | ($urandom & ~mask);
      csr_access(1'b1, idx, data, readback);
      sb.write_reg(idx, data);
      csr_access(1'b0, idx, '0, readback);
      if ((readback & mask) !== (data & mask)) begin
         $error("csr index %0d: expected %0h, got %0h", idx, data & mask, readback & mask);
         sb.mismatches++;
      end
   endtask

   // stop offering and wait until every owed result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // new settings, then a batch of random points from several regions
   task automatic run_phase(input int lim, input int pal, input int points, input bit idling);
      logic [COORD_W-1:0] cr, ci;
      int                 pick;
      drain_results();
      program_reg(bship_pkg::CSR_IDX_MAX_ITER, lim);
      program_reg(bship_pkg::CSR_IDX_PALETTE, pal);
      idle_on = idling;
      repeat (points) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            cr = $urandom;
            ci = $urandom;
         end else if (pick < 22) begin
            cr = corner_coord();
            ci = corner_coord();
         end else if (pick < 45) begin
            cr = spread('0, Q_HALF);
            ci = spread('0, Q_HALF);
         end else if (pick < 75) begin
            cr = spread(-(Q_ONE - Q_ONE / 4), Q_ONE);
            ci = spread('0, Q_ONE);
         end else begin
            cr = spread('0, Q_TWO + Q_HALF);
            ci = spread('0, Q_TWO + Q_HALF);
         end
         send_point(cr, ci, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
   endtask

   // both channels sampled at the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_result(rsp_out_x, rsp_out_y, rsp_escaped, rsp_iteration_count,
                            rsp_color_index);
         end
         if (req_valid && req_ready) begin
            sb.note_point(req_c_real, req_c_imag, req_pixel_x, req_pixel_y);
         end
      end
   end

   // receiver: bursts of ready with random pauses, one long hold-off to back up the block
   initial begin : rsp_side
      int burst, pause;
      bit held;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         burst = $urandom_range(1, 40);
         repeat (burst) @(posedge clock);
         if (!held && sb.checked >= HOLD_AFTER) begin
            held  = 1'b1;
            pause = HOLD_CYCLES;
         end else begin
            pause = gap_cycles();
         end
         if (pause > 0) begin
            rsp_ready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
      end
   end

   // watchdog on cycles with no item moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int k;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed points at the reset settings
      send_point(32'h0000_0000, 32'h0000_0000, 10'd0, 10'd0);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd1023, 10'd1023);
      send_point(32'h8000_0000, 32'h8000_0000, 10'd0, 10'd1023);
      send_point(32'h7FFF_FFFF, 32'h8000_0000, 10'd1023, 10'd0);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 10'd512, 10'd256);
      // |z|^2 lands exactly on 4, and just below it
      send_point(Q_TWO, 32'h0, 10'd1, 10'd2);
      send_point(Q_TWO - 1, 32'h0, 10'd3, 10'd4);
      send_point(-Q_TWO, 32'h0, 10'd5, 10'd6);
      send_point(32'h0, Q_TWO, 10'd7, 10'd8);
      send_point(32'h0, -Q_TWO, 10'd9, 10'd10);
      // bounded orbits on and near the real axis
      send_point(-Q_ONE, 32'h0, 10'd11, 10'd12);
      send_point(32'hE400_0000, 32'h0, 10'd13, 10'd14);
      send_point(32'hE3E0_0000, 32'hFF80_0000, 10'd15, 10'd16);
      // tiny values: floor rounding of negative differences
      send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd17, 10'd18);
      send_point(32'h0000_0001, 32'h0000_0001, 10'd19, 10'd20);
      send_point(Q_ONE / 4, -Q_HALF, 10'd21, 10'd22);
      send_point(32'h5555_5555, 32'hAAAA_AAAA, 10'h155, 10'h2AA);
      send_point(32'hAAAA_AAAA, 32'h5555_5555, 10'h2AA, 10'h155);
      send_point(-Q_HALF, -Q_HALF, 10'd23, 10'd24);
      send_point(32'h0400_0000, 32'h0, 10'd25, 10'd26);
      send_point(32'h0400_0001, 32'h0, 10'd27, 10'd28);

      // extreme settings: zero limit, single step, saturated limit and palette
      run_phase(0, 0, 30, 1'b1);
      run_phase(1, 1, 60, 1'b1);
      run_phase(2, 511, 60, 1'b0);
      run_phase(2047, 256, 12, 1'b1);
      run_phase(1024, 255, 10, 1'b1);
      for (k = 0; k < 8; k++) begin
         run_phase($urandom_range(1, 100), $urandom_range(0, 511), 105,
                   $urandom_range(0, 4) != 0);
      end

      drain_results();
      if (sb.mismatches == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[burning_ship_escape_time_top.f]
+incdir+rtl
rtl/bship_pkg.sv
rtl/burning_ship_escape_time_top.sv
tb/tb_burning_ship_escape_time_top.sv
